>>> rtl/rdc_pkg.sv
// shared types, constants and the symbol lookup for the radix digit converter
`default_nettype none

package rdc_pkg;

	localparam int STEP_BITS = 8;
	localparam int RADIX_W = 5;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic REG_RADIX = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} rdc_state_t;

	function automatic logic [6:0] symbol_of(input logic [3:0] d);
		logic [6:0] s;
		if (d < 4'd10) begin
			s = 7'h30 + {3'b000, d};
		end else begin
			s = 7'h37 + {3'b000, d};
		end
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/radix_digit_converter.sv
// top level: converts an unsigned number into digits of a configurable radix
//
// usage: radix (2..16) is written over the apb port at byte address 0 while idle.
// a number is taken on start when busy is low. results come out one digit per
// cycle, most significant first, each marked by strobe for one cycle; last marks
// the final digit. the receiver cannot stall, so strobe is never held back.
// the divider consumes STEP_BITS dividend bits per cycle, and one digit takes
// a pass over the whole dividend; a number of n digits is first divided out
// in full, then emitted out of the digit memory, one read per cycle, through
// its registered read port. zero gives one digit.
// a radix outside 2..16 gives a single beat with bad_radix set in the cycle
// after start, and busy never rises.
// busy is high from the cycle after start until the last digit read is issued;
// a new number may be taken while that last beat is shown.
// reset clears control state and sets radix to 10; the digit memory is
// not cleared, since every entry read is written first.
`default_nettype none

module radix_digit_converter
	import rdc_pkg::*;
#(
	parameter int VALUE_BITS = 64,
	parameter int MAX_DIGITS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	input  wire logic [63:0] value,
	output logic             busy,
	output logic             strobe,
	output logic [3:0]       digit,
	output logic [6:0]       symbol,
	output logic             last,
	output logic             bad_radix
);

	localparam int PASSES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int QW = PASSES * STEP_BITS;
	localparam int PW = $clog2(PASSES + 1);
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int AW = $clog2(MAX_DIGITS);

	rdc_state_t state_q, state_n;

	logic [RADIX_W-1:0] radix_q;
	logic [QW-1:0]      quot_q;
	logic [3:0]         rem_q;
	logic               nz_q;
	logic [PW-1:0]      pass_q;
	logic [CW-1:0]      cnt_q;
	logic [AW-1:0]      ptr_q;
	logic               strobe_q;
	logic               last_q;
	logic               bad_q;
	logic [3:0]         rd_q;

	logic [3:0] digit_mem [MAX_DIGITS];

	logic                 cfg_wr;
	logic                 accept;
	logic                 radix_ok;
	logic [STEP_BITS-1:0] qbits;
	logic [3:0]           rem_n;
	logic                 nz_n;
	logic                 pass_end;
	logic [CW-1:0]        cnt_n;
	logic                 mem_we;
	logic                 mem_re;
	logic                 emit_end;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_RADIX) ? {{(32 - RADIX_W){1'b0}}, radix_q} : 32'd0;

	assign accept   = start && !busy;
	assign radix_ok = (radix_q >= RADIX_MIN) && (radix_q <= RADIX_MAX);

	// restoring long division, STEP_BITS dividend bits per cycle
	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, quot_q[QW-1-i]};
			if (t >= radix_q) begin
				qbits[STEP_BITS-1-i] = 1'b1;
				r = 4'(t - radix_q);
			end else begin
				r = t[3:0];
			end
		end
		rem_n = r;
	end

	assign nz_n     = nz_q || (|qbits);
	assign pass_end = (pass_q == PW'(PASSES - 1));
	assign cnt_n    = (cnt_q < CW'(MAX_DIGITS)) ? cnt_q + 1'b1 : cnt_q;
	assign emit_end = (ptr_q == '0);

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && radix_ok) begin
					state_n = ST_DIV;
				end
			end
			ST_DIV: begin
				if (pass_end && !nz_n) begin
					state_n = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_end) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		busy   = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_DIV: begin
				busy   = 1'b1;
				mem_we = pass_end && (cnt_q < CW'(MAX_DIGITS));
			end
			ST_EMIT: begin
				busy   = 1'b1;
				mem_re = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radix_q  <= RADIX_RESET;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			bad_q    <= 1'b0;
			pass_q   <= '0;
			cnt_q    <= '0;
			ptr_q    <= '0;
			nz_q     <= 1'b0;
			rem_q    <= '0;
			quot_q   <= '0;
		end else begin
			state_q  <= state_n;
			strobe_q <= 1'b0;
			if (cfg_wr && (paddr[2] == REG_RADIX)) begin
				radix_q <= pwdata[RADIX_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (radix_ok) begin
							quot_q <= QW'(value[VALUE_BITS-1:0]);
							rem_q  <= '0;
							nz_q   <= 1'b0;
							pass_q <= '0;
							cnt_q  <= '0;
						end else begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							bad_q    <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					quot_q <= QW'(quot_q << STEP_BITS) | QW'(qbits);
					if (pass_end) begin
						cnt_q  <= cnt_n;
						rem_q  <= '0;
						nz_q   <= 1'b0;
						pass_q <= '0;
						ptr_q  <= AW'(cnt_n - 1'b1);
					end else begin
						rem_q  <= rem_n;
						nz_q   <= nz_n;
						pass_q <= pass_q + 1'b1;
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					last_q   <= emit_end;
					bad_q    <= 1'b0;
					ptr_q    <= ptr_q - 1'b1;
				end
				default: begin
					strobe_q <= 1'b0;
				end
			endcase
		end
	end

	// digit stack memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[AW-1:0]] <= rem_n;
		end
		if (mem_re) begin
			rd_q <= digit_mem[ptr_q];
		end
	end

	assign strobe    = strobe_q;
	assign last      = last_q;
	assign bad_radix = bad_q;
	assign digit     = bad_q ? 4'd0 : rd_q;
	assign symbol    = bad_q ? 7'd0 : symbol_of(rd_q);

endmodule

`default_nettype wire

>>> rtl/rdc_checker.sv
// port-level checks for the radix digit converter and their bind
`default_nettype none

module rdc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       strobe,
	input wire logic [3:0] digit,
	input wire logic [6:0] symbol,
	input wire logic       last,
	input wire logic       bad_radix
);

	// a bad radix beat carries no digit and ends the number
	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_radix |-> (digit == 4'd0) && (symbol == 7'd0) && last)
		else $error("bad radix beat malformed");

	// symbol is the ascii form of the digit
	a_symbol: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !bad_radix |->
			((digit < 4'd10) && (symbol == 7'h30 + {3'b000, digit})) ||
			((digit >= 4'd10) && (symbol == 7'h37 + {3'b000, digit})))
		else $error("symbol does not match digit");

	// more digits to come keep the block busy
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("idle while digits still pending");

	// an accepted number starts work or answers with an error beat
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || (strobe && bad_radix))
		else $error("accepted number dropped");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.digit     (digit),
	.symbol    (symbol),
	.last      (last),
	.bad_radix (bad_radix)
);

`default_nettype wire
